FILE: rtl/bnodo_pkg.sv
// ----------------------------------------------------------------------------
// Base-N odometer package
// Widths, the character table and the control program of the digit adder.
// ----------------------------------------------------------------------------
package bnodo_pkg;

  localparam int MAX_DIGITS   = 10;
  localparam int NUM_CHAR_OUT = 10;
  localparam int STEP_W       = 60;
  localparam int DIGIT_W      = 6;
  localparam int CHAR_W       = 7;
  localparam int LEN_W        = 4;
  localparam int RADIX_MIN    = 2;
  localparam int RADIX_MAX    = 62;
  localparam int IN_TDATA_W   = ((STEP_W + 7) / 8) * 8;
  localparam int OUT_DATA_W   = NUM_CHAR_OUT * CHAR_W;
  localparam int OUT_TDATA_W  = ((OUT_DATA_W + 7) / 8) * 8;
  localparam int CFG_ADDR_W   = 1;
  localparam int CFG_DATA_W   = 6;
  localparam int DIG_IDX_W    = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int CNT_W        = $clog2(MAX_DIGITS + 1);
  localparam int DIV_BITS     = 6;
  localparam int DIV_STEPS    = (STEP_W + DIV_BITS - 1) / DIV_BITS;
  localparam int DIV_CNT_W    = $clog2(DIV_STEPS + 1);
  localparam int PC_W         = 3;

  localparam logic [CFG_ADDR_W-1:0] REG_LENGTH = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_RADIX  = 1'b1;

  localparam logic [LEN_W-1:0]   LENGTH_RST = 4'd10;
  localparam logic [DIGIT_W-1:0] RADIX_RST  = 6'd62;

  typedef logic [PC_W-1:0] pc_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_DIV_INIT,
    OP_DIV,
    OP_ADD,
    OP_FINISH,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    CND_NEVER,
    CND_ALWAYS,
    CND_NO_IN,
    CND_DONE,
    CND_DIV_MORE,
    CND_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } uword_t;

  localparam pc_t PC_LOAD   = 3'd0;
  localparam pc_t PC_TEST   = 3'd1;
  localparam pc_t PC_DIV    = 3'd2;
  localparam pc_t PC_ADD    = 3'd3;
  localparam pc_t PC_FINISH = 3'd4;
  localparam pc_t PC_WAIT   = 3'd5;
  localparam pc_t PC_EMIT   = 3'd6;

  // A jump is taken when the condition holds, otherwise the program falls through.
  function automatic uword_t ucode(input pc_t pc);
    uword_t w;
    case (pc)
      PC_LOAD:   w = '{op: OP_LOAD,     cond: CND_NO_IN,    target: PC_LOAD};
      PC_TEST:   w = '{op: OP_DIV_INIT, cond: CND_DONE,     target: PC_FINISH};
      PC_DIV:    w = '{op: OP_DIV,      cond: CND_DIV_MORE, target: PC_DIV};
      PC_ADD:    w = '{op: OP_ADD,      cond: CND_ALWAYS,   target: PC_TEST};
      PC_FINISH: w = '{op: OP_FINISH,   cond: CND_NEVER,    target: PC_LOAD};
      PC_WAIT:   w = '{op: OP_NOP,      cond: CND_OUT_BUSY, target: PC_WAIT};
      PC_EMIT:   w = '{op: OP_EMIT,     cond: CND_ALWAYS,   target: PC_LOAD};
      default:   w = '{op: OP_NOP,      cond: CND_ALWAYS,   target: PC_LOAD};
    endcase
    return w;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < 6'd26) begin
      c = 7'h61 + CHAR_W'(d);
    end else if (d < 6'd52) begin
      c = 7'h41 + CHAR_W'(d - 6'd26);
    end else if (d < 6'd62) begin
      c = 7'h30 + CHAR_W'(d - 6'd52);
    end else begin
      c = '0;
    end
    return c;
  endfunction

endpackage

FILE: rtl/base_n_odometer_candidate_gen.sv
// ----------------------------------------------------------------------------
// Base-N odometer candidate generator
// Adds a step amount to a little-endian base-N counter under control of a
// small microcode program and maps each digit to an alphanumeric character.
// ----------------------------------------------------------------------------
// Channel | Direction | Contents
// in_     | slave     | tdata: step
// out_    | master    | tuser: overflow; tdata: char_0 .. char_9
// cfg_    | write     | index 0 length, index 1 radix
//
// An item visits digits until the carried step is zero or the effective length
// is reached; each visited digit runs the shared six-bit-per-cycle divider
// plus a test and an add step.
// Reset is synchronous and active low; it clears the counter and restores the
// registers to length 10 and radix 62.
// A stalled output holds the sequencer before it loads the output register.
// ----------------------------------------------------------------------------
module base_n_odometer_candidate_gen (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [bnodo_pkg::IN_TDATA_W-1:0]    in_tdata,   // step
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [bnodo_pkg::OUT_TDATA_W-1:0]   out_tdata,  // char_0 .. char_9
  output logic                                out_tuser,  // overflow
  input  logic                                cfg_we,
  input  logic [bnodo_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [bnodo_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int SW = bnodo_pkg::STEP_W;
  localparam int DW = bnodo_pkg::DIGIT_W;

  logic [bnodo_pkg::LEN_W-1:0]      length_r;
  logic [DW-1:0]                    radix_r;
  bnodo_pkg::pc_t                   pc_r, pc_nxt;
  logic [SW-1:0]                    n_r, n_nxt;
  logic [DW-1:0]                    rem_r, rem_nxt;
  logic [bnodo_pkg::DIV_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [bnodo_pkg::CNT_W-1:0]      i_r, i_nxt;
  logic [DW-1:0]                    digits_r [bnodo_pkg::MAX_DIGITS];
  logic [DW-1:0]                    dig_wdata;
  logic                             dig_we, dig_clr;
  logic                             ovf_r, ovf_nxt;
  logic                             out_tvalid_r;
  logic                             out_tuser_r;
  logic [bnodo_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic                             emit;
  bnodo_pkg::uword_t                uw;
  logic                             jump;
  logic                             in_xfer;
  logic [DW-1:0]                    rad_eff;
  logic [bnodo_pkg::CNT_W-1:0]      len_eff;
  logic [bnodo_pkg::LEN_W:0]        len_ext;
  logic [DW-1:0]                    div_rem;
  logic [SW-1:0]                    div_n;
  logic [DW:0]                      t;
  logic [DW:0]                      sum;
  logic                             carry;

  assign uw        = bnodo_pkg::ucode(pc_r);
  assign in_tready = (pc_r == bnodo_pkg::PC_LOAD);
  assign in_xfer   = in_tvalid && in_tready;

  always_comb begin
    if (radix_r < DW'(bnodo_pkg::RADIX_MIN)) begin
      rad_eff = DW'(bnodo_pkg::RADIX_MIN);
    end else if (radix_r > DW'(bnodo_pkg::RADIX_MAX)) begin
      rad_eff = DW'(bnodo_pkg::RADIX_MAX);
    end else begin
      rad_eff = radix_r;
    end
  end

  always_comb begin
    len_ext = {1'b0, length_r};
    if (length_r == '0) begin
      len_eff = bnodo_pkg::CNT_W'(1);
    end else if (len_ext > (bnodo_pkg::LEN_W + 1)'(bnodo_pkg::MAX_DIGITS)) begin
      len_eff = bnodo_pkg::CNT_W'(bnodo_pkg::MAX_DIGITS);
    end else begin
      len_eff = bnodo_pkg::CNT_W'(len_ext);
    end
  end

  // Restoring division, most significant bits first; quotient bits enter at the bottom.
  always_comb begin
    div_rem = rem_r;
    div_n   = n_r;
    t       = '0;
    for (int j = 0; j < bnodo_pkg::DIV_BITS; j++) begin
      t     = {div_rem, div_n[SW-1]};
      div_n = {div_n[SW-2:0], 1'b0};
      if (t >= {1'b0, rad_eff}) begin
        t        = t - {1'b0, rad_eff};
        div_n[0] = 1'b1;
      end
      div_rem = t[DW-1:0];
    end
  end

  always_comb begin
    sum   = {1'b0, digits_r[i_r[bnodo_pkg::DIG_IDX_W-1:0]]} + {1'b0, rem_r};
    carry = 1'b0;
    if (sum >= {1'b0, rad_eff}) begin
      sum   = sum - {1'b0, rad_eff};
      carry = 1'b1;
    end
    if (sum >= {1'b0, rad_eff}) begin
      sum = {1'b0, rad_eff} - 1'b1;
    end
  end

  always_comb begin
    case (uw.cond)
      bnodo_pkg::CND_NEVER:    jump = 1'b0;
      bnodo_pkg::CND_ALWAYS:   jump = 1'b1;
      bnodo_pkg::CND_NO_IN:    jump = !in_xfer;
      bnodo_pkg::CND_DONE:     jump = (n_r == '0) || (i_r == len_eff);
      bnodo_pkg::CND_DIV_MORE: jump = (cnt_r != bnodo_pkg::DIV_CNT_W'(1));
      bnodo_pkg::CND_OUT_BUSY: jump = out_tvalid_r;
      default:                 jump = 1'b0;
    endcase
    pc_nxt = jump ? uw.target : pc_r + 1'b1;
  end

  always_comb begin
    n_nxt     = n_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    i_nxt     = i_r;
    ovf_nxt   = ovf_r;
    dig_we    = 1'b0;
    dig_clr   = 1'b0;
    dig_wdata = sum[DW-1:0];
    emit      = 1'b0;
    case (uw.op)
      bnodo_pkg::OP_LOAD: begin
        if (in_xfer) begin
          n_nxt   = in_tdata[SW-1:0];
          i_nxt   = '0;
          ovf_nxt = 1'b0;
        end
      end
      bnodo_pkg::OP_DIV_INIT: begin
        rem_nxt = '0;
        cnt_nxt = bnodo_pkg::DIV_CNT_W'(bnodo_pkg::DIV_STEPS);
      end
      bnodo_pkg::OP_DIV: begin
        n_nxt   = div_n;
        rem_nxt = div_rem;
        cnt_nxt = cnt_r - 1'b1;
      end
      bnodo_pkg::OP_ADD: begin
        dig_we = 1'b1;
        n_nxt  = n_r + SW'(carry);
        i_nxt  = i_r + 1'b1;
      end
      bnodo_pkg::OP_FINISH: begin
        if (n_r != '0) begin
          dig_clr = 1'b1;
          ovf_nxt = 1'b1;
        end
      end
      bnodo_pkg::OP_EMIT: emit = 1'b1;
      default: begin
      end
    endcase
  end

  generate
    for (genvar k = 0; k < bnodo_pkg::NUM_CHAR_OUT; k++) begin : g_char
      if (k < bnodo_pkg::MAX_DIGITS) begin : g_dig
        assign out_data_nxt[k*bnodo_pkg::CHAR_W +: bnodo_pkg::CHAR_W] =
          (bnodo_pkg::CNT_W'(k) < len_eff) ? bnodo_pkg::digit_char(digits_r[k]) : '0;
      end else begin : g_none
        assign out_data_nxt[k*bnodo_pkg::CHAR_W +: bnodo_pkg::CHAR_W] = '0;
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      length_r     <= bnodo_pkg::LENGTH_RST;
      radix_r      <= bnodo_pkg::RADIX_RST;
      pc_r         <= bnodo_pkg::PC_LOAD;
      out_tvalid_r <= 1'b0;
      for (int k = 0; k < bnodo_pkg::MAX_DIGITS; k++) begin
        digits_r[k] <= '0;
      end
    end else begin
      if (cfg_we && (cfg_addr == bnodo_pkg::REG_LENGTH)) begin
        length_r <= cfg_wdata[bnodo_pkg::LEN_W-1:0];
      end
      if (cfg_we && (cfg_addr == bnodo_pkg::REG_RADIX)) begin
        radix_r <= cfg_wdata[DW-1:0];
      end
      pc_r <= pc_nxt;
      if (emit) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      if (dig_clr) begin
        for (int k = 0; k < bnodo_pkg::MAX_DIGITS; k++) begin
          digits_r[k] <= '0;
        end
      end else if (dig_we) begin
        digits_r[i_r[bnodo_pkg::DIG_IDX_W-1:0]] <= dig_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    n_r   <= n_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    i_r   <= i_nxt;
    ovf_r <= ovf_nxt;
    if (emit) begin
      out_data_r  <= out_data_nxt;
      out_tuser_r <= ovf_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_tuser_r;
  assign out_tdata  = {{(bnodo_pkg::OUT_TDATA_W - bnodo_pkg::OUT_DATA_W){1'b0}}, out_data_r};

endmodule
